// ----- sv/lca_pkg.sv -----
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants for the life grid
// Opcodes, result codes, register indexes, control structs and the rule.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int LCA_MAX_COLS = 64;
  localparam int LCA_MAX_ROWS = 64;

  localparam int COORD_W = 7;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 7'd64;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 7'd64;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic [1:0] CELL_DEAD    = 2'd0;
  localparam logic [1:0] CELL_OUTSIDE = 2'd2;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_READ   = 2'd2,
    OP_STEP   = 2'd3
  } op_t;

  typedef struct packed {
    logic clr_en;
    logic latch;
    logic scan_start;
    logic scan_en;
    logic lookup;
    logic flip;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_step;
    logic scan_last;
    logic pipe_busy;
  } dp_status_t;

  function automatic logic next_cell(input logic [7:0] nbrs, input logic self);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(nbrs[i]);
    end
    return (cnt == BIRTH_COUNT) || (self && (cnt == SURVIVE_LOW));
  endfunction

endpackage

// ----- sv/lca_in_if.sv -----
// ----------------------------------------------------------------------------
// lca_in_if: operation channel
// Valid/ready channel carrying one grid operation per transaction.
// ----------------------------------------------------------------------------
interface lca_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] col;
  logic [6:0] row;
  logic       new_value;

  modport source (output valid, output opcode, output col, output row,
                  output new_value, input ready);
  modport sink (input valid, input opcode, input col, input row,
                input new_value, output ready);
endinterface

// ----- sv/lca_out_if.sv -----
// ----------------------------------------------------------------------------
// lca_out_if: result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface lca_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_state;
  logic       any_changed;

  modport source (output valid, output cell_state, output any_changed,
                  input ready);
  modport sink (input valid, input cell_state, input any_changed,
                output ready);
endinterface

// ----- sv/lca_ram.sv -----
// ----------------------------------------------------------------------------
// lca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lca_ctrl.sv -----
// ----------------------------------------------------------------------------
// lca_ctrl: controller for the life grid
// Sequences clearing, cell access, generation scan and result handoff.
// ----------------------------------------------------------------------------
module lca_ctrl
  import lca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ACCESS = 7'b0000100,
    ST_LOOKUP = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.latch      = in_ready && in_valid;
    out_valid_nxt  = out_valid_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd.scan_start = 1'b1;
        state_nxt = st.is_step ? ST_SCAN : ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          cmd.flip  = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free)
    else $error("result loaded over a pending transaction");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> state_r == ST_CLEAR)
    else $error("reset did not start the clearing pass");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && st.scan_last) |=> state_r == ST_DRAIN)
    else $error("scan end not followed by drain");

endmodule

// ----- sv/lca_dp.sv -----
// ----------------------------------------------------------------------------
// lca_dp: datapath for the life grid
// Two cell banks, a line buffer, the scan window and the result registers.
// ----------------------------------------------------------------------------
module lca_dp
  import lca_pkg::*;
#(
  parameter int MAX_COLS = LCA_MAX_COLS,
  parameter int MAX_ROWS = LCA_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [1:0]         in_opcode,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  input  logic               in_new_value,
  output logic [1:0]         out_cell_state,
  output logic               out_any_changed
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int LBW   = $clog2(MAX_COLS);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int CMPW  = (MW > COORD_W) ? MW : COORD_W;

  logic [CFG_W-1:0]   grid_width_r, grid_height_r;
  logic [CW-1:0]      w_eff;
  logic [RW-1:0]      h_eff;
  op_t                op_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic               val_r;
  logic               on_grid;
  logic [AW-1:0]      acc_addr;
  logic [AW-1:0]      clr_addr_r;
  logic               sel_r;
  logic [1:0]         res_state_r;
  logic               changed_r;
  logic [1:0]         out_state_r;
  logic               out_changed_r;

  logic [CW-1:0]      sc_col_r, c1_r, c2_r;
  logic [RW-1:0]      sc_row_r, r1_r, r2_r;
  logic               v1_r, v2_r;
  logic [2:0]         win_l_r, win_m_r, win_r_r;
  logic [AW-1:0]      scan_raddr, scan_waddr, raddr;
  logic [1:0]         lb_q;
  logic               lb_we;
  logic [2:0]         tri_col;
  logic               bot;
  logic [7:0]         nbrs;
  logic               next_bit;
  logic               q0, q1, live_q;
  logic               look_we, look_wd;
  logic               we0, we1, wd0, wd1;
  logic [AW-1:0]      wa0, wa1;

  // effective grid size
  always_comb begin
    if (grid_width_r == '0) w_eff = CW'(1);
    else if (32'(grid_width_r) > 32'(MAX_COLS)) w_eff = CW'(MAX_COLS);
    else w_eff = CW'(grid_width_r);
    if (grid_height_r == '0) h_eff = RW'(1);
    else if (32'(grid_height_r) > 32'(MAX_ROWS)) h_eff = RW'(MAX_ROWS);
    else h_eff = RW'(grid_height_r);
  end

  assign on_grid  = (CMPW'(col_r) < CMPW'(w_eff)) && (CMPW'(row_r) < CMPW'(h_eff));
  assign acc_addr = AW'(32'(row_r) * MAX_COLS + 32'(col_r));

  assign scan_raddr = AW'(32'(sc_row_r) * MAX_COLS + 32'(sc_col_r));
  assign scan_waddr = AW'(32'(r2_r) * MAX_COLS + 32'(c2_r));
  assign raddr      = cmd.scan_en ? scan_raddr : acc_addr;

  assign live_q  = sel_r ? q1 : q0;
  assign look_we = cmd.lookup && on_grid && (op_r == OP_SET || op_r == OP_TOGGLE);
  assign look_wd = (op_r == OP_TOGGLE) ? !live_q : val_r;

  // stage 1: vertical triple for column c1
  always_comb begin
    bot     = ((c1_r < w_eff) && (r1_r < h_eff)) ? live_q : 1'b0;
    tri_col = (r1_r == '0) ? {2'b00, bot} : {lb_q, bot};
    if (c1_r == w_eff) tri_col = 3'b000;
    lb_we   = v1_r && (c1_r < w_eff);
  end

  // stage 2: rule on the window centered at column c2
  assign nbrs     = {win_l_r, win_r_r, win_m_r[2], win_m_r[0]};
  assign next_bit = next_cell(nbrs, win_m_r[1]);

  always_comb begin
    we0 = cmd.clr_en || (look_we && !sel_r) || (v2_r && sel_r);
    we1 = cmd.clr_en || (look_we && sel_r) || (v2_r && !sel_r);
    wa0 = cmd.clr_en ? clr_addr_r : (v2_r ? scan_waddr : acc_addr);
    wa1 = wa0;
    wd0 = cmd.clr_en ? 1'b0 : (v2_r ? next_bit : look_wd);
    wd1 = wd0;
  end

  lca_ram #(.WIDTH(1), .DEPTH(CELLS)) u_bank0 (
    .clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(raddr), .rdata(q0)
  );

  lca_ram #(.WIDTH(1), .DEPTH(CELLS)) u_bank1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(raddr), .rdata(q1)
  );

  lca_ram #(.WIDTH(2), .DEPTH(MAX_COLS)) u_line (
    .clk(clk), .we(lb_we), .waddr(LBW'(c1_r)), .wdata(tri_col[1:0]),
    .raddr(LBW'(sc_col_r)), .rdata(lb_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RESET;
      grid_height_r <= GRID_HEIGHT_RESET;
      clr_addr_r    <= '0;
      sel_r         <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      sc_col_r      <= '0;
      sc_row_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_en) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.flip) sel_r <= !sel_r;
      v1_r <= cmd.scan_en;
      v2_r <= v1_r && (c1_r != '0) && (r1_r != '0);
      if (cmd.scan_start) begin
        sc_col_r <= '0;
        sc_row_r <= '0;
      end else if (cmd.scan_en) begin
        if (sc_col_r == w_eff) begin
          sc_col_r <= '0;
          sc_row_r <= sc_row_r + RW'(1);
        end else begin
          sc_col_r <= sc_col_r + CW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_opcode);
      col_r <= in_col;
      row_r <= in_row;
      val_r <= in_new_value;
    end
    c1_r <= sc_col_r;
    r1_r <= sc_row_r;
    c2_r <= c1_r - CW'(1);
    r2_r <= r1_r - RW'(1);
    if (v1_r) begin
      if (c1_r == '0) begin
        win_l_r <= 3'b000;
        win_m_r <= 3'b000;
      end else begin
        win_l_r <= win_m_r;
        win_m_r <= win_r_r;
      end
      win_r_r <= tri_col;
    end
    if (cmd.lookup) begin
      res_state_r <= on_grid ? {1'b0, live_q} : CELL_OUTSIDE;
    end
    if (cmd.scan_start) begin
      changed_r <= 1'b0;
    end else if (v2_r && (next_bit != win_m_r[1])) begin
      changed_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_state_r   <= (op_r == OP_READ) ? res_state_r : CELL_DEAD;
      out_changed_r <= (op_r == OP_STEP) ? changed_r : 1'b0;
    end
  end

  assign st.clr_done  = (clr_addr_r == AW'(CELLS - 1));
  assign st.is_step   = (op_r == OP_STEP);
  assign st.scan_last = (sc_col_r == w_eff) && (sc_row_r == h_eff);
  assign st.pipe_busy = v1_r || v2_r;

  assign out_cell_state  = out_state_r;
  assign out_any_changed = out_changed_r;

  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && (v2_r || look_we)))
    else $error("clearing pass collides with a cell write");

  a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (c2_r < w_eff) && (r2_r < h_eff))
    else $error("generation write outside the grid");

  a_flip_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flip |-> !v1_r && !v2_r && !cmd.scan_en)
    else $error("bank swap while the scan pipeline is busy");

endmodule

// ----- sv/life_cellular_automaton_grid.sv -----
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid: B3/S23 life grid, bounded and non-wrapping
// Set, toggle, read and step operations over a configurable grid.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Set, toggle and read pass from
// acceptance through the access, lookup and result states to the result
// register. A step scans the grid in raster order at one cell per cycle over
// a margin row and column, using the single read port of the cell bank, with
// a line buffer holding the two rows above. After reset a clearing pass over
// all MAX_COLS*MAX_ROWS cells runs before the first operation is taken.
// A new operation is taken while the previous result waits.
module life_cellular_automaton_grid
  import lca_pkg::*;
#(
  parameter int MAX_COLS = LCA_MAX_COLS,
  parameter int MAX_ROWS = LCA_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst_n,
  lca_in_if.sink           in_if,
  lca_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  lca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .st        (st),
    .cmd       (cmd)
  );

  lca_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (in_if.opcode),
    .in_col          (in_if.col),
    .in_row          (in_if.row),
    .in_new_value    (in_if.new_value),
    .out_cell_state  (out_if.cell_state),
    .out_any_changed (out_if.any_changed)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: life grid regression
// Drives set, toggle, read and step operations over several grid sizes,
// predicts each result with a local B3/S23 grid and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import lca_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_ITEMS  = 112;

  typedef struct packed {
    op_t        opcode;
    logic [6:0] col;
    logic [6:0] row;
    logic       new_value;
    logic       known;
    logic [1:0] cell_state;
    logic       any_changed;
  } stim_row_t;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       any_changed;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_GRID_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  lca_in_if  in_if();
  lca_out_if out_if();

  life_cellular_automaton_grid u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic         cells [2][LCA_MAX_COLS*LCA_MAX_ROWS];
  logic         bank;
  int           cols_used;
  int           rows_used;
  grid_result_t pending_results[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           sink_hold = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_SET;
    in_if.col = '0;
    in_if.row = '0;
    in_if.new_value = 1'b0;
    out_if.ready = 1'b0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic int clamp_size(input logic [6:0] v, input int max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic bit on_grid(input int c, input int r);
    return c >= 0 && c < cols_used && r >= 0 && r < rows_used;
  endfunction

  function automatic int alive_at(input int c, input int r);
    if (!on_grid(c, r)) return 0;
    return cells[bank][r*LCA_MAX_COLS+c];
  endfunction

  function automatic logic advance_generation();
    logic changed;
    logic self_v;
    logic nxt;
    int   cnt;
    changed = 1'b0;
    for (int r = 0; r < rows_used; r++) begin
      for (int c = 0; c < cols_used; c++) begin
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) cnt += alive_at(c+dc, r+dr);
        self_v = alive_at(c, r);
        nxt = self_v ? (cnt == 2 || cnt == 3) : (cnt == 3);
        if (nxt != self_v) changed = 1'b1;
        cells[~bank][r*LCA_MAX_COLS+c] = nxt;
      end
    end
    bank = ~bank;
    return changed;
  endfunction

  function automatic grid_result_t predict_grid(input op_t op, input int c, input int r,
                                                input logic v);
    grid_result_t res;
    res = '0;
    case (op)
      OP_SET:    if (on_grid(c, r)) cells[bank][r*LCA_MAX_COLS+c] = v;
      OP_TOGGLE: if (on_grid(c, r)) cells[bank][r*LCA_MAX_COLS+c] ^= 1'b1;
      OP_READ:   res.cell_state = on_grid(c, r) ? 2'(alive_at(c, r)) : CELL_OUTSIDE;
      default:   res.any_changed = advance_generation();
    endcase
    return res;
  endfunction

  task automatic write_reg(input logic idx, input logic [6:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_WIDTH) cols_used = clamp_size(v, LCA_MAX_COLS);
    else rows_used = clamp_size(v, LCA_MAX_ROWS);
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_op(input op_t op, input logic [6:0] c, input logic [6:0] r,
                         input logic v, input bit known, input grid_result_t want);
    grid_result_t res;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.col <= c;
    in_if.row <= r;
    in_if.new_value <= v;
    do @(posedge clk); while (!in_if.ready);
    res = predict_grid(op, c, r, v);
    if (known && res != want) report("directed table", res, want);
    pending_results.push_back(res);
  endtask

  task automatic send_idle_gap();
    in_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    grid_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.cell_state !== want.cell_state)
            report("cell_state", out_if.cell_state, want.cell_state);
          if (out_if.any_changed !== want.any_changed)
            report("any_changed", out_if.any_changed, want.any_changed);
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{OP_READ,   7'd0,   7'd0,   1'b0, 1'b1, CELL_DEAD,    1'b0},
    '{OP_READ,   7'd63,  7'd63,  1'b0, 1'b1, CELL_DEAD,    1'b0},
    '{OP_READ,   7'd64,  7'd0,   1'b0, 1'b1, CELL_OUTSIDE, 1'b0},
    '{OP_READ,   7'd0,   7'd127, 1'b0, 1'b1, CELL_OUTSIDE, 1'b0},
    '{OP_STEP,   7'd0,   7'd0,   1'b0, 1'b1, CELL_DEAD,    1'b0},
    '{OP_SET,    7'd0,   7'd0,   1'b1, 1'b1, CELL_DEAD,    1'b0},
    '{OP_READ,   7'd0,   7'd0,   1'b0, 1'b1, 2'd1,         1'b0},
    '{OP_SET,    7'd127, 7'd127, 1'b1, 1'b1, CELL_DEAD,    1'b0},
    '{OP_TOGGLE, 7'd127, 7'd5,   1'b0, 1'b1, CELL_DEAD,    1'b0},
    '{OP_SET,    7'd1,   7'd0,   1'b1, 1'b0, CELL_DEAD,    1'b0},
    '{OP_SET,    7'd2,   7'd0,   1'b1, 1'b0, CELL_DEAD,    1'b0},
    '{OP_STEP,   7'd0,   7'd0,   1'b0, 1'b0, CELL_DEAD,    1'b0},
    '{OP_READ,   7'd1,   7'd1,   1'b0, 1'b0, CELL_DEAD,    1'b0},
    '{OP_STEP,   7'd0,   7'd0,   1'b0, 1'b0, CELL_DEAD,    1'b0},
    '{OP_TOGGLE, 7'd63,  7'd63,  1'b0, 1'b0, CELL_DEAD,    1'b0},
    '{OP_READ,   7'd63,  7'd63,  1'b0, 1'b0, CELL_DEAD,    1'b0},
    '{OP_SET,    7'd63,  7'd63,  1'b0, 1'b0, CELL_DEAD,    1'b0},
    '{OP_STEP,   7'd0,   7'd0,   1'b0, 1'b0, CELL_DEAD,    1'b0}
  };

  task automatic random_phase(input int count);
    int  op_pick;
    op_t op;
    logic [6:0] c;
    logic [6:0] r;
    for (int i = 0; i < count; i++) begin
      op_pick = $urandom_range(0, 9);
      op = (op_pick < 4) ? OP_SET : (op_pick < 5) ? OP_TOGGLE :
           (op_pick < 8) ? OP_READ : OP_STEP;
      if ($urandom_range(0, 7) == 0) begin
        c = 7'($urandom);
        r = 7'($urandom);
      end else begin
        c = 7'($urandom_range(0, cols_used - 1));
        r = 7'($urandom_range(0, rows_used - 1));
      end
      send_op(op, c, r, 1'($urandom), 1'b0, '0);
    end
    send_idle_gap();
  endtask

  initial begin
    logic [6:0] widths  [5] = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd3};
    logic [6:0] heights [5] = '{7'd64, 7'd1, 7'd2, 7'd7, 7'd127};
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < LCA_MAX_COLS*LCA_MAX_ROWS; i++) cells[b][i] = 1'b0;
    bank = 1'b0;
    cols_used = 64;
    rows_used = 64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_op(directed[i].opcode, directed[i].col, directed[i].row, directed[i].new_value,
              directed[i].known, {directed[i].cell_state, directed[i].any_changed});
    send_idle_gap();
    drain();
    // full-grid steps above wrote every cell of both banks
    for (int p = 1; p < 5; p++) begin
      write_reg(CFG_GRID_WIDTH, widths[p]);
      write_reg(CFG_GRID_HEIGHT, heights[p]);
      random_phase(RAND_ITEMS / 4);
      drain();
    end
    write_reg(CFG_GRID_WIDTH, 7'd3);
    write_reg(CFG_GRID_HEIGHT, 7'd3);
    random_phase(10);
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
